FILE: rtl/aebr_pkg.sv
// Package for the adaptive envelope beat-rate detector.
// Holds shared constants and the sequencer state type; depends on nothing.
package aebr_pkg;

    localparam int SAMPLE_BITS_DEF = 16;
    localparam int RING_DEPTH_DEF  = 16;

    localparam int FRAC_BITS = 8;
    localparam int TIME_W    = 32;
    localparam int RATE_W    = 16;
    localparam int WINDOW_W  = 5;

    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 5'd10;
    localparam int                  WINDOW_MIN   = 2;

    // Milliseconds per minute times the Q12.4 fraction scale
    localparam int RATE_SCALE = 60000 * 16;
    localparam logic [RATE_W-1:0] RATE_MAX = '1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOW,
        ST_LOW_WAIT,
        ST_UP,
        ST_UP_WAIT,
        ST_BEAT,
        ST_SPAN,
        ST_RATE_WAIT,
        ST_OUT
    } aebr_state_t;

endpackage

FILE: rtl/aebr_if.sv
// Handshake channel interfaces of the beat-rate detector: samples, results, configuration.
// Depends on aebr_pkg.
interface aebr_sample_if #(
    parameter int SAMPLE_BITS = aebr_pkg::SAMPLE_BITS_DEF
);
    import aebr_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample_value;
    logic [TIME_W-1:0]      sample_time_ms;

    modport source (output valid, output sample_value, output sample_time_ms, input ready);
    modport sink   (input valid, input sample_value, input sample_time_ms, output ready);
endinterface

interface aebr_result_if;
    import aebr_pkg::*;

    logic              valid;
    logic              ready;
    logic              beat_detected;
    logic [RATE_W-1:0] rate_bpm_q4;
    logic              rate_valid;

    modport source (output valid, output beat_detected, output rate_bpm_q4,
                    output rate_valid, input ready);
    modport sink   (input valid, input beat_detected, input rate_bpm_q4,
                    input rate_valid, output ready);
endinterface

interface aebr_cfg_if;
    import aebr_pkg::*;

    logic                valid;
    logic                ready;
    logic [WINDOW_W-1:0] beat_window;

    modport source (output valid, output beat_window, input ready);
    modport sink   (input valid, input beat_window, output ready);
endinterface

FILE: rtl/adaptive_envelope_beat_rate.sv
// Top level of the adaptive envelope beat-rate detector: sequencer, envelopes, beat ring.
// Depends on aebr_pkg, the channel interfaces, aebr_div and aebr_ram.
//
// Usage
//   sample : sink channel; each item is one pulse sample and its timestamp in ms.
//   result : source channel; one item per sample: beat flag, Q12.4 rate, rate-valid.
//   cfg    : write channel for beat_window (always ready; write only while idle).
// Each sample widens to Q16.8. The lower and upper envelopes jump to a new
// extreme or step toward the sample by difference / window, one after the other
// on a shared restoring divider (width DW = max(SAMPLE_BITS+8, numerator bits),
// 24 by default). A falling midpoint crossing is a beat: its time enters a ring
// RAM, the oldest time is read back and the rate divided out on the same
// divider. One sample is in work at a time, so a new item is taken only once
// the last result has been loaded into the output register. Reset loads
// window 10, empties the ring and sets the envelopes to all ones and zero;
// the ring RAM itself is not cleared. A finished result waits in the output
// register while the receiver stalls; the next sample is still taken, and its
// result waits for the register to empty.
module adaptive_envelope_beat_rate #(
    parameter int RING_DEPTH  = aebr_pkg::RING_DEPTH_DEF,
    parameter int SAMPLE_BITS = aebr_pkg::SAMPLE_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    aebr_sample_if.sink   sample,
    aebr_result_if.source result,
    aebr_cfg_if.sink      cfg
);
    import aebr_pkg::*;

    localparam int EW     = SAMPLE_BITS + FRAC_BITS;
    localparam int AW     = $clog2(RING_DEPTH);
    localparam int CW     = $clog2(RING_DEPTH + 1);
    localparam int NUM_W  = $clog2(RING_DEPTH * RATE_SCALE);
    localparam int DW     = (EW > NUM_W) ? EW : NUM_W;
    localparam int WCMP_W = (CW > WINDOW_W) ? CW : WINDOW_W;

    // ring slot of base + offset, both below the depth
    function automatic logic [AW-1:0] slot_add(input logic [AW-1:0] base,
                                               input logic [CW-1:0] off);
        logic [CW:0] s;
        s = (CW+1)'(base) + (CW+1)'(off);
        if (s >= (CW+1)'(RING_DEPTH))
        begin
            s = s - (CW+1)'(RING_DEPTH);
        end
        return s[AW-1:0];
    endfunction

    aebr_state_t state_reg, state_next;

    logic [WINDOW_W-1:0] window_reg;
    logic [EW-1:0]       lower_reg, lower_next;
    logic [EW-1:0]       upper_reg, upper_next;
    logic                falling_reg, falling_next;
    logic [AW-1:0]       oldest_reg, oldest_next;
    logic [CW-1:0]       count_reg, count_next;

    logic [EW-1:0]       y_reg;
    logic [TIME_W-1:0]   t_reg;
    logic [NUM_W-1:0]    num_reg, num_next;

    logic                pend_beat_reg, pend_beat_next;
    logic                pend_valid_reg, pend_valid_next;
    logic [RATE_W-1:0]   pend_rate_reg, pend_rate_next;

    logic                out_valid_reg;
    logic                out_beat_reg;
    logic                out_rate_valid_reg;
    logic [RATE_W-1:0]   out_rate_reg;
    logic                out_load;

    logic                div_start;
    logic [DW-1:0]       div_dividend;
    logic [TIME_W-1:0]   div_divisor;
    logic                div_done;
    logic [DW-1:0]       div_quotient;

    logic                ram_we;
    logic [AW-1:0]       wr_slot;
    logic [TIME_W-1:0]   ram_rd_data;

    logic [WCMP_W-1:0]   win_ext;
    logic [CW-1:0]       win;
    logic [EW-1:0]       mid;
    logic [CW-1:0]       cnt_inc;
    logic                drop;
    logic [CW-1:0]       cnt_kept;
    logic [AW-1:0]       oldest_kept;
    logic [TIME_W-1:0]   span;
    logic                accept;

    // clamp the window to [2, RING_DEPTH]
    assign win_ext = WCMP_W'(window_reg);
    always_comb
    begin
        if (win_ext < WCMP_W'(WINDOW_MIN))
        begin
            win = CW'(WINDOW_MIN);
        end
        else if (win_ext > WCMP_W'(RING_DEPTH))
        begin
            win = CW'(RING_DEPTH);
        end
        else
        begin
            win = win_ext[CW-1:0];
        end
    end

    // midpoint of the updated envelopes; lower <= upper holds here
    assign mid = lower_reg + ((upper_reg - lower_reg) >> 1);

    // append at the tail, then drop the oldest once the window is reached
    assign wr_slot     = slot_add(oldest_reg, count_reg);
    assign cnt_inc     = count_reg + 1'b1;
    assign drop        = cnt_inc >= win;
    assign cnt_kept    = drop ? cnt_inc - 1'b1 : cnt_inc;
    assign oldest_kept = drop ? slot_add(oldest_reg, CW'(1)) : oldest_reg;

    // newest time is the sample's own; the oldest comes from the RAM
    assign span = t_reg - ram_rd_data;

    assign accept       = sample.valid && sample.ready;
    assign sample.ready = (state_reg == ST_IDLE);
    assign cfg.ready    = 1'b1;

    always_comb
    begin
        state_next      = state_reg;
        lower_next      = lower_reg;
        upper_next      = upper_reg;
        falling_next    = falling_reg;
        oldest_next     = oldest_reg;
        count_next      = count_reg;
        num_next        = num_reg;
        pend_beat_next  = pend_beat_reg;
        pend_valid_next = pend_valid_reg;
        pend_rate_next  = pend_rate_reg;
        div_start       = 1'b0;
        div_dividend    = '0;
        div_divisor     = '0;
        ram_we          = 1'b0;
        out_load        = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (sample.valid)
                begin
                    state_next = ST_LOW;
                end
            end
            ST_LOW:
            begin
                if (y_reg < lower_reg)
                begin
                    lower_next = y_reg;
                    state_next = ST_UP;
                end
                else
                begin
                    div_start    = 1'b1;
                    div_dividend = DW'(y_reg - lower_reg);
                    div_divisor  = TIME_W'(win);
                    state_next   = ST_LOW_WAIT;
                end
            end
            ST_LOW_WAIT:
            begin
                if (div_done)
                begin
                    lower_next = lower_reg + div_quotient[EW-1:0];
                    state_next = ST_UP;
                end
            end
            ST_UP:
            begin
                if (y_reg > upper_reg)
                begin
                    upper_next = y_reg;
                    state_next = ST_BEAT;
                end
                else
                begin
                    div_start    = 1'b1;
                    div_dividend = DW'(upper_reg - y_reg);
                    div_divisor  = TIME_W'(win);
                    state_next   = ST_UP_WAIT;
                end
            end
            ST_UP_WAIT:
            begin
                if (div_done)
                begin
                    upper_next = upper_reg - div_quotient[EW-1:0];
                    state_next = ST_BEAT;
                end
            end
            ST_BEAT:
            begin
                pend_beat_next  = 1'b0;
                pend_valid_next = 1'b0;
                pend_rate_next  = '0;
                state_next      = ST_OUT;
                if (y_reg < mid)
                begin
                    if (!falling_reg)
                    begin
                        falling_next   = 1'b1;
                        pend_beat_next = 1'b1;
                        ram_we         = 1'b1;
                        oldest_next    = oldest_kept;
                        count_next     = cnt_kept;
                        num_next       = NUM_W'(cnt_kept) * NUM_W'(RATE_SCALE);
                        // a lone entry means a zero span: no rate
                        if (cnt_kept != CW'(1))
                        begin
                            state_next = ST_SPAN;
                        end
                    end
                end
                else
                begin
                    falling_next = 1'b0;
                end
            end
            ST_SPAN:
            begin
                if (span == '0)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    div_start    = 1'b1;
                    div_dividend = DW'(num_reg);
                    div_divisor  = span;
                    state_next   = ST_RATE_WAIT;
                end
            end
            ST_RATE_WAIT:
            begin
                if (div_done)
                begin
                    pend_valid_next = 1'b1;
                    // saturate the rate to its 16 bits
                    pend_rate_next  = (|div_quotient[DW-1:RATE_W]) ? RATE_MAX
                                                                  : div_quotient[RATE_W-1:0];
                    state_next      = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            window_reg     <= WINDOW_RESET;
            lower_reg      <= '1;
            upper_reg      <= '0;
            falling_reg    <= 1'b0;
            oldest_reg     <= '0;
            count_reg      <= '0;
            pend_beat_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            lower_reg      <= lower_next;
            upper_reg      <= upper_next;
            falling_reg    <= falling_next;
            oldest_reg     <= oldest_next;
            count_reg      <= count_next;
            pend_beat_reg  <= pend_beat_next;
            pend_valid_reg <= pend_valid_next;
            if (cfg.valid)
            begin
                window_reg <= cfg.beat_window;
            end
            // hold the result until taken
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            y_reg <= {sample.sample_value, {FRAC_BITS{1'b0}}};
            t_reg <= sample.sample_time_ms;
        end
        num_reg       <= num_next;
        pend_rate_reg <= pend_rate_next;
        if (out_load)
        begin
            out_beat_reg       <= pend_beat_reg;
            out_rate_valid_reg <= pend_valid_reg;
            out_rate_reg       <= pend_rate_reg;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.beat_detected = out_beat_reg;
    assign result.rate_valid    = out_rate_valid_reg;
    assign result.rate_bpm_q4   = out_rate_reg;

    aebr_div #(
        .DIVIDEND_W (DW),
        .DIVISOR_W  (TIME_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // read address follows the next oldest slot so the data is ready in ST_SPAN
    aebr_ram #(
        .WIDTH (TIME_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk     (clk),
        .we      (ram_we),
        .wr_addr (wr_slot),
        .wr_data (t_reg),
        .rd_addr (oldest_next),
        .rd_data (ram_rd_data)
    );

endmodule

FILE: rtl/aebr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package needed.
module aebr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: rtl/aebr_div.sv
// Restoring serial divider, one quotient bit per cycle.
// Standalone; used for the envelope steps and the rate.
module aebr_div #(
    parameter int DIVIDEND_W = 24,
    parameter int DIVISOR_W  = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  dsr_reg, dsr_next;

    logic [DIVISOR_W:0]    rem_shift;
    logic                  fits;

    assign rem_shift = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign fits      = rem_shift >= {1'b0, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIVIDEND_W);
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            // shift in the next dividend bit, subtract where the divisor fits
            rem_next = fits ? DIVISOR_W'(rem_shift - {1'b0, dsr_reg})
                            : rem_shift[DIVISOR_W-1:0];
            quo_next = {quo_reg[DIVIDEND_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: dv/tb_top.sv
// Self-checking bench for adaptive_envelope_beat_rate: pulse trains and noise in, beat/rate out.
// Depends on aebr_pkg, the channel interfaces in aebr_if.sv and the top-level RTL.
module tb_top;
    import aebr_pkg::*;

    typedef struct packed {
        logic [15:0] value;
        logic [31:0] stamp;
    } pulse_sample_t;

    typedef struct packed {
        logic        beat;
        logic [15:0] rate_q4;
        logic        rate_ok;
    } beat_verdict_t;

    logic clk = 1'b0;
    logic rst_n;

    aebr_sample_if #(.SAMPLE_BITS(SAMPLE_BITS_DEF)) smp ();
    aebr_result_if                                  res ();
    aebr_cfg_if                                     cfg_ch ();

    adaptive_envelope_beat_rate #(
        .RING_DEPTH  (RING_DEPTH_DEF),
        .SAMPLE_BITS (SAMPLE_BITS_DEF)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (smp),
        .result (res),
        .cfg    (cfg_ch)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Samples waiting for the driver, and verdicts waiting for the block's results
    pulse_sample_t pending_samples[$];
    beat_verdict_t expected_beats[$];

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned error_count   = 0;
    int unsigned pushed_total  = 0;
    logic [31:0] now_ms        = '0;

    // Long receiver hold-off: bump hold_arm to start one
    int unsigned hold_arm  = 0;
    int unsigned hold_seen = 0;
    int unsigned hold_left = 0;

    // Shadow of the detector state, kept in step with accepted samples
    logic [4:0]  window_reg = WINDOW_RESET;
    logic [23:0] env_low    = '1;
    logic [23:0] env_high   = '0;
    logic        falling    = 1'b0;
    logic [31:0] beat_ring [RING_DEPTH_DEF];
    logic [3:0]  ring_head  = '0;
    logic [4:0]  ring_count = '0;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        begin
            $display("%0t: %s got %0h want %0h", $time, what, got, want);
            error_count++;
        end
    endtask

    // Advance the envelopes, detect the falling crossing and work out the rate
    task automatic predict_beat(input logic [15:0] value, input logic [31:0] stamp);
        logic [23:0]     y;
        logic [23:0]     mid_env;
        logic [4:0]      w;
        logic [3:0]      newest;
        logic [31:0]     span;
        longint unsigned numer;
        longint unsigned rate_wide;
        beat_verdict_t   v;
        begin
            y = {value, {FRAC_BITS{1'b0}}};
            // clamp the window into [2, ring depth]
            if (window_reg < WINDOW_MIN)
                w = 5'(WINDOW_MIN);
            else if (window_reg > RING_DEPTH_DEF)
                w = 5'(RING_DEPTH_DEF);
            else
                w = window_reg;

            if (y < env_low)
                env_low = y;
            else
                env_low = env_low + (y - env_low) / w;

            if (y > env_high)
                env_high = y;
            else
                env_high = env_high - (env_high - y) / w;

            mid_env = env_low + ((env_high - env_low) >> 1);
            v = '0;

            if (y < mid_env)
            begin
                if (!falling)
                begin
                    falling = 1'b1;
                    v.beat  = 1'b1;
                    // append first, then drop the oldest once the history is full
                    beat_ring[ring_head + ring_count[3:0]] = stamp;
                    ring_count = ring_count + 5'd1;
                    if (ring_count >= w)
                    begin
                        ring_head  = ring_head + 4'd1;
                        ring_count = ring_count - 5'd1;
                    end
                    newest = ring_head + ring_count[3:0] - 4'd1;
                    span   = beat_ring[newest] - beat_ring[ring_head];
                    if (span != 0)
                    begin
                        v.rate_ok = 1'b1;
                        numer     = ring_count;
                        numer     = numer * RATE_SCALE;
                        rate_wide = numer / span;
                        v.rate_q4 = (rate_wide > RATE_MAX) ? RATE_MAX : rate_wide[15:0];
                    end
                end
            end
            else
            begin
                falling = 1'b0;
            end
            expected_beats.push_back(v);
        end
    endtask

    // Sample driver: offer the next queued item whenever the slot is free
    always @(posedge clk)
    begin : drive_samples
        pulse_sample_t next_item;
        if (rst_n)
        begin
            if (smp.valid && smp.ready)
                predict_beat(smp.sample_value, smp.sample_time_ms);
            if (!smp.valid || smp.ready)
            begin
                if (pending_samples.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    next_item          = pending_samples.pop_front();
                    smp.valid          <= 1'b1;
                    smp.sample_value   <= next_item.value;
                    smp.sample_time_ms <= next_item.stamp;
                end
                else
                begin
                    smp.valid <= 1'b0;
                end
            end
        end
    end

    // Count down a requested hold-off in cycles
    always @(posedge clk)
    begin
        if (hold_seen != hold_arm)
        begin
            hold_seen <= hold_arm;
            hold_left <= 600;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // Result monitor: compare each accepted item with the oldest verdict
    always @(posedge clk)
    begin : watch_results
        beat_verdict_t want;
        if (rst_n)
        begin
            if (res.valid && res.ready)
            begin
                if (expected_beats.size() == 0)
                begin
                    report_mismatch("result with nothing pending", res.rate_bpm_q4, 0);
                end
                else
                begin
                    want = expected_beats.pop_front();
                    if (res.beat_detected !== want.beat)
                        report_mismatch("beat_detected", res.beat_detected, want.beat);
                    if (res.rate_bpm_q4 !== want.rate_q4)
                        report_mismatch("rate_bpm_q4", res.rate_bpm_q4, want.rate_q4);
                    if (res.rate_valid !== want.rate_ok)
                        report_mismatch("rate_valid", res.rate_valid, want.rate_ok);
                end
            end
            res.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    task automatic push_sample(input logic [15:0] value, input logic [31:0] stamp);
        begin
            pending_samples.push_back('{value: value, stamp: stamp});
            pushed_total++;
        end
    endtask

    // One pulse train: a high run then a low run per beat, at a chosen sample spacing
    task automatic push_pulse_train();
        int unsigned beats;
        int unsigned half;
        int unsigned step;
        int unsigned hi;
        int unsigned lo;
        int unsigned pick;
        begin
            beats = $urandom_range(2, 12);
            half  = $urandom_range(1, 5);
            pick  = $urandom_range(0, 9);
            if (pick < 7)
                step = $urandom_range(1, 60);
            else if (pick == 7)
                step = 0;                       // every beat on one timestamp
            else if (pick == 8)
                step = $urandom_range(1000, 200000);
            else
                step = $urandom_range(0, 1);    // drives the rate into saturation
            hi = $urandom_range(40000, 65535);
            lo = $urandom_range(0, 25000);
            for (int b = 0; b < beats; b++)
            begin
                for (int k = 0; k < half; k++)
                begin
                    push_sample(16'(hi - $urandom_range(0, 2000)), now_ms);
                    now_ms = now_ms + step;
                end
                for (int k = 0; k < half; k++)
                begin
                    push_sample(16'(lo + $urandom_range(0, 2000)), now_ms);
                    now_ms = now_ms + step;
                end
            end
        end
    endtask

    // Noise: any value, with the clock creeping, jumping anywhere or standing still
    task automatic push_noise_sample();
        int unsigned pick;
        begin
            pick = $urandom_range(0, 19);
            if (pick < 14)
                now_ms = now_ms + $urandom_range(0, 50);
            else if (pick < 17)
                now_ms = $urandom;
            push_sample(16'($urandom_range(0, 65535)), now_ms);
        end
    endtask

    // Block on the pipe running dry: nothing queued, offered or owed
    task automatic wait_drained();
        begin
            do
                @(negedge clk);
            while (pending_samples.size() != 0 || smp.valid || expected_beats.size() != 0);
        end
    endtask

    task automatic write_window(input logic [4:0] w);
        begin
            @(posedge clk);
            cfg_ch.valid       <= 1'b1;
            cfg_ch.beat_window <= w;
            do
                @(posedge clk);
            while (!(cfg_ch.valid && cfg_ch.ready));
            window_reg = w;
            cfg_ch.valid <= 1'b0;
        end
    endtask

    initial
    begin : run_regression
        logic [4:0]  phase_window [8];
        int unsigned phase_start;
        begin
            phase_window = '{5'd2, 5'd16, 5'd0, 5'd31, 5'd1, 5'd17, 5'd5, 5'd12};

            rst_n              = 1'b0;
            smp.valid          = 1'b0;
            smp.sample_value   = '0;
            smp.sample_time_ms = '0;
            res.ready          = 1'b0;
            cfg_ch.valid       = 1'b0;
            cfg_ch.beat_window = '0;
            send_idle_pct      = 27;
            recv_idle_pct      = 57;

            repeat (6) @(posedge clk);
            rst_n <= 1'b1;

            // Directed opening at the reset window: field extremes, a first beat with
            // no span, a saturated rate, a repeated oldest time, a wrapped span
            push_sample(16'hFFFF, 32'h0000_0000);
            push_sample(16'h0000, 32'h0000_0001);
            push_sample(16'hFFFF, 32'h0000_0002);
            push_sample(16'h0000, 32'h0000_0003);
            push_sample(16'hFFFF, 32'h0000_0003);
            push_sample(16'h0000, 32'h0000_0001);
            push_sample(16'hFFFF, 32'hFFFF_FFFF);
            push_sample(16'h0000, 32'hFFFF_FFFF);
            push_sample(16'h8000, 32'hFFFF_FFFF);
            push_sample(16'hAAAA, 32'h8000_0000);
            push_sample(16'h5555, 32'h8000_0010);
            push_sample(16'hFFFF, 32'h5555_5555);
            push_sample(16'h0001, 32'hAAAA_AAAA);
            push_sample(16'hFFFE, 32'hAAAA_AAAA);
            push_sample(16'h7FFF, 32'hAAAA_B000);
            push_sample(16'h0000, 32'hAAAA_C000);
            wait_drained();

            for (int phase = 0; phase < 8; phase++)
            begin
                // sparse receiver first, then sparse sender, then full rate
                if (phase < 3)
                begin
                    send_idle_pct = 27;
                    recv_idle_pct = 57;
                end
                else if (phase < 6)
                begin
                    send_idle_pct = 57;
                    recv_idle_pct = 27;
                end
                else
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
                write_window(phase_window[phase]);
                if (phase == 6)
                    hold_arm <= hold_arm + 1;   // stall the receiver while samples pile up

                now_ms      = $urandom;
                phase_start = pushed_total;
                while (pushed_total - phase_start < 240)
                begin
                    if ($urandom_range(0, 4) != 0)
                        push_pulse_train();
                    else
                        push_noise_sample();
                end
                wait_drained();
            end

            // let any stray result surface before the verdict
            repeat (120) @(posedge clk);
            if (error_count == 0)
                $display("adaptive_envelope_beat_rate regression: pass");
            else
                $display("adaptive_envelope_beat_rate regression: fail");
            $finish;
        end
    end

    initial
    begin
        #25_000_000;
        $display("adaptive_envelope_beat_rate regression: fail");
        $finish;
    end

endmodule

FILE: adaptive_envelope_beat_rate.f
rtl/aebr_pkg.sv
rtl/aebr_if.sv
rtl/aebr_ram.sv
rtl/aebr_div.sv
rtl/adaptive_envelope_beat_rate.sv
dv/tb_top.sv
